// ===== rtl/xalu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// x86-64 add/sub ALU package
// Operation codes, flag bit positions and the structs passed between the
// ALU datapath and the top level.
// ----------------------------------------------------------------------------
package xalu_pkg;

   typedef enum logic [3:0] {
      OP_ADD        = 4'd0,
      OP_ADC        = 4'd1,
      OP_SUB        = 4'd2,
      OP_SBB        = 4'd3,
      OP_CMP        = 4'd4,
      OP_NEG        = 4'd5,
      OP_INC        = 4'd6,
      OP_DEC        = 4'd7,
      OP_XADD       = 4'd8,
      OP_CMPXCHG    = 4'd9,
      OP_CMPXCHG16B = 4'd10,
      OP_CDQE       = 4'd11,
      OP_CQO        = 4'd12
   } op_type;

   localparam int FLAG_CF = 0;
   localparam int FLAG_PF = 1;
   localparam int FLAG_AF = 2;
   localparam int FLAG_ZF = 3;
   localparam int FLAG_SF = 4;
   localparam int FLAG_OF = 5;

   localparam int FLAG_W = 6;

   typedef logic [FLAG_W-1:0] flags_type;

   typedef struct packed {
      op_type      operation;
      logic [63:0] dest_value;
      logic [63:0] dest_high_value;
      logic [63:0] source_value;
      logic        imm_sign_extend;
      logic [63:0] acc_low;
      logic [63:0] acc_high;
      logic [63:0] swap_low;
      logic [63:0] swap_high;
      logic        misaligned;
   } req_type;

   typedef struct packed {
      logic [63:0] dest_result;
      logic [63:0] dest_high_result;
      logic        dest_write;
      logic [63:0] other_result;
      logic [63:0] other_high_result;
      logic        other_write;
      flags_type   flags_out;
      logic        fault;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/xalu_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ALU request channel
// Valid/ready channel carrying one operation beat to the ALU.
// ----------------------------------------------------------------------------
interface xalu_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  operation;
   logic [63:0] dest_value;
   logic [63:0] dest_high_value;
   logic [63:0] source_value;
   logic        imm_sign_extend;
   logic [63:0] acc_low;
   logic [63:0] acc_high;
   logic [63:0] swap_low;
   logic [63:0] swap_high;
   logic        misaligned;

   modport source (
      output valid, operation, dest_value, dest_high_value, source_value,
             imm_sign_extend, acc_low, acc_high, swap_low, swap_high, misaligned,
      input  ready
   );

   modport sink (
      input  valid, operation, dest_value, dest_high_value, source_value,
             imm_sign_extend, acc_low, acc_high, swap_low, swap_high, misaligned,
      output ready
   );
endinterface
`default_nettype wire

// ===== rtl/xalu_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ALU response channel
// Valid/ready channel carrying one result beat from the ALU.
// ----------------------------------------------------------------------------
interface xalu_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] dest_result;
   logic [63:0] dest_high_result;
   logic        dest_write;
   logic [63:0] other_result;
   logic [63:0] other_high_result;
   logic        other_write;
   logic [5:0]  flags_out;
   logic        fault;

   modport source (
      output valid, dest_result, dest_high_result, dest_write, other_result,
             other_high_result, other_write, flags_out, fault,
      input  ready
   );

   modport sink (
      input  valid, dest_result, dest_high_result, dest_write, other_result,
             other_high_result, other_write, flags_out, fault,
      output ready
   );
endinterface
`default_nettype wire

// ===== rtl/xalu_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// x86-64 add/sub ALU datapath
// One shared 64-bit adder with flag generation, compare-exchange selection
// and sign extension, all combinational.
// ----------------------------------------------------------------------------
module xalu_core (
   input  var xalu_pkg::req_type   req_in,
   input  var xalu_pkg::flags_type flags_in,
   output xalu_pkg::rsp_type       rsp_out
);
   import xalu_pkg::*;

   logic [63:0] src;
   logic [63:0] add_a;
   logic [63:0] add_b;
   logic        is_sub;
   logic        carry_in;
   logic [64:0] sum;
   logic [63:0] res;
   flags_type   arith_flags;
   flags_type   keep_cf_flags;
   logic        match16;

   always_comb begin
      src = req_in.imm_sign_extend
          ? {{32{req_in.source_value[31]}}, req_in.source_value[31:0]}
          : req_in.source_value;
      add_a    = req_in.dest_value;
      add_b    = src;
      is_sub   = 1'b0;
      carry_in = 1'b0;
      case (req_in.operation)
         OP_ADC: begin
            carry_in = flags_in[FLAG_CF];
         end
         OP_SUB, OP_CMP: begin
            is_sub = 1'b1;
         end
         OP_SBB: begin
            is_sub   = 1'b1;
            carry_in = flags_in[FLAG_CF];
         end
         OP_NEG: begin
            add_a  = 64'd0;
            add_b  = req_in.dest_value;
            is_sub = 1'b1;
         end
         OP_INC: begin
            add_b = 64'd1;
         end
         OP_DEC: begin
            add_b  = 64'd1;
            is_sub = 1'b1;
         end
         OP_CMPXCHG: begin
            add_a  = req_in.acc_low;
            add_b  = req_in.dest_value;
            is_sub = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Subtraction runs as a + ~b + ~borrow; the carry out is the inverted borrow.
   assign sum = {1'b0, add_a} + {1'b0, (is_sub ? ~add_b : add_b)}
              + {64'd0, carry_in ^ is_sub};
   assign res = sum[63:0];

   always_comb begin
      arith_flags          = '0;
      arith_flags[FLAG_CF] = sum[64] ^ is_sub;
      arith_flags[FLAG_PF] = ~^res[7:0];
      arith_flags[FLAG_AF] = add_a[4] ^ add_b[4] ^ res[4];
      arith_flags[FLAG_ZF] = (res == 64'd0);
      arith_flags[FLAG_SF] = res[63];
      arith_flags[FLAG_OF] = is_sub
                           ? ((add_a[63] ^ add_b[63]) & (add_a[63] ^ res[63]))
                           : ((add_a[63] ^ res[63]) & (add_b[63] ^ res[63]));
      keep_cf_flags          = arith_flags;
      keep_cf_flags[FLAG_CF] = flags_in[FLAG_CF];
   end

   assign match16 = (req_in.acc_low == req_in.dest_value)
                 && (req_in.acc_high == req_in.dest_high_value);

   always_comb begin
      rsp_out = '0;
      rsp_out.flags_out = flags_in;
      case (req_in.operation)
         OP_ADD, OP_ADC, OP_SUB, OP_SBB, OP_NEG: begin
            rsp_out.dest_result = res;
            rsp_out.dest_write  = 1'b1;
            rsp_out.flags_out   = arith_flags;
         end
         OP_CMP: begin
            rsp_out.flags_out = arith_flags;
         end
         OP_INC, OP_DEC: begin
            rsp_out.dest_result = res;
            rsp_out.dest_write  = 1'b1;
            rsp_out.flags_out   = keep_cf_flags;
         end
         OP_XADD: begin
            rsp_out.dest_result  = res;
            rsp_out.dest_write   = 1'b1;
            rsp_out.other_result = req_in.dest_value;
            rsp_out.other_write  = 1'b1;
            rsp_out.flags_out    = arith_flags;
         end
         OP_CMPXCHG: begin
            rsp_out.flags_out = arith_flags;
            if (arith_flags[FLAG_ZF]) begin
               rsp_out.dest_result = src;
               rsp_out.dest_write  = 1'b1;
            end else begin
               rsp_out.other_result = req_in.dest_value;
               rsp_out.other_write  = 1'b1;
            end
         end
         OP_CMPXCHG16B: begin
            if (req_in.misaligned) begin
               rsp_out.fault = 1'b1;
            end else if (match16) begin
               rsp_out.dest_result         = req_in.swap_low;
               rsp_out.dest_high_result    = req_in.swap_high;
               rsp_out.dest_write          = 1'b1;
               rsp_out.flags_out[FLAG_ZF]  = 1'b1;
            end else begin
               rsp_out.other_result        = req_in.dest_value;
               rsp_out.other_high_result   = req_in.dest_high_value;
               rsp_out.other_write         = 1'b1;
               rsp_out.flags_out[FLAG_ZF]  = 1'b0;
            end
         end
         OP_CDQE: begin
            rsp_out.dest_result = {{32{req_in.dest_value[31]}}, req_in.dest_value[31:0]};
            rsp_out.dest_write  = 1'b1;
         end
         OP_CQO: begin
            rsp_out.dest_result = {64{req_in.dest_value[63]}};
            rsp_out.dest_write  = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/x86_64_add_sub_alu_with_flags_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// x86-64 add/sub ALU with status flags
// Requests are registered in stage 1, results in the output register.
// One beat is accepted every cycle while the output advances; the flags
// register feeds the single adder stage directly; back-to-back carries do
// not stall. Synchronous reset empties both stages and clears all six flags.
// ----------------------------------------------------------------------------
module x86_64_add_sub_alu_with_flags_top (
   input  wire         clock,
   input  wire         reset,
   xalu_req_if.sink    req,
   xalu_rsp_if.source  rsp
);
   import xalu_pkg::*;

   logic      s1_valid_ff;
   logic      s1_valid_in;
   req_type   s1_data_ff;
   req_type   req_data;
   logic      out_valid_ff;
   logic      out_valid_in;
   rsp_type   out_data_ff;
   rsp_type   core_rsp;
   flags_type flags_ff;
   flags_type flags_in;
   logic      advance;

   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = !s1_valid_ff || advance;

   always_comb begin
      req_data.operation       = op_type'(req.operation);
      req_data.dest_value      = req.dest_value;
      req_data.dest_high_value = req.dest_high_value;
      req_data.source_value    = req.source_value;
      req_data.imm_sign_extend = req.imm_sign_extend;
      req_data.acc_low         = req.acc_low;
      req_data.acc_high        = req.acc_high;
      req_data.swap_low        = req.swap_low;
      req_data.swap_high       = req.swap_high;
      req_data.misaligned      = req.misaligned;
   end

   xalu_core u_core (
      .req_in   (s1_data_ff),
      .flags_in (flags_ff),
      .rsp_out  (core_rsp)
   );

   always_comb begin
      s1_valid_in  = req.ready ? req.valid : s1_valid_ff;
      out_valid_in = advance ? s1_valid_ff : out_valid_ff;
      flags_in     = (s1_valid_ff && advance) ? core_rsp.flags_out : flags_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         flags_ff     <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         s1_data_ff <= req_data;
      end
      if (s1_valid_ff && advance) begin
         out_data_ff <= core_rsp;
      end
   end

   assign rsp.valid             = out_valid_ff;
   assign rsp.dest_result       = out_data_ff.dest_result;
   assign rsp.dest_high_result  = out_data_ff.dest_high_result;
   assign rsp.dest_write        = out_data_ff.dest_write;
   assign rsp.other_result      = out_data_ff.other_result;
   assign rsp.other_high_result = out_data_ff.other_high_result;
   assign rsp.other_write       = out_data_ff.other_write;
   assign rsp.flags_out         = out_data_ff.flags_out;
   assign rsp.fault             = out_data_ff.fault;

endmodule
`default_nettype wire
